// ----- hw/rtl/pbd_pkg.sv -----
package pbd_pkg;

    localparam int ROW_BYTES     = 72;
    localparam int ROWS          = 720;
    localparam int HEADER_BYTES  = 512;
    localparam int WRAPPER_BYTES = 128;

    localparam int IMAGE_BYTES = ROW_BYTES * ROWS;
    localparam int COUNT_W     = $clog2(IMAGE_BYTES + 1);
    localparam int CMP_W       = (COUNT_W > 8) ? COUNT_W : 8;

    localparam logic [COUNT_W-1:0] IMAGE_END = COUNT_W'(IMAGE_BYTES);

    localparam logic [9:0] HEADER_LAST  = 10'(HEADER_BYTES - 1);
    localparam logic [9:0] WRAPPER_LAST = 10'(WRAPPER_BYTES - 1);
    localparam logic [9:0] MARK_FIRST   = 10'h080;
    localparam logic [9:0] MARK_END     = 10'h086;

    localparam logic [7:0] CTRL_NOP   = 8'h80;
    localparam logic [8:0] RUN_BASE   = 9'h101;

    typedef struct packed {
        logic        valid;
        logic [7:0]  pixel_byte;
        logic [7:0]  repeat_res;
        logic [15:0] image_offset;
        logic        image_done;
    } pbd_result_t;

endpackage

// ----- hw/rtl/pbd_core.sv -----
module pbd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data,
    output pbd_pkg::pbd_result_t res
);
    import pbd_pkg::*;

    typedef enum logic [1:0] {PH_HEADER, PH_WRAPPER, PH_DATA, PH_DONE} phase_t;

    localparam phase_t PH_START = (HEADER_BYTES > 0) ? PH_HEADER : PH_DATA;

    phase_t               phase_reg, phase_next;
    logic [9:0]           pos_reg, pos_next;
    logic                 wrapped_reg, wrapped_next;
    logic [6:0]           lit_reg, lit_next;
    logic [7:0]           run_reg, run_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic [COUNT_W-1:0]   left;
    logic [7:0]           rep;

    always_comb
    begin
        left = IMAGE_END - count_reg;
        if (CMP_W'(run_reg) > CMP_W'(left))
        begin
            rep = 8'(left);
        end
        else
        begin
            rep = run_reg;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        wrapped_next = wrapped_reg;
        lit_next     = lit_reg;
        run_next     = run_reg;
        count_next   = count_reg;
        res.valid        = 1'b0;
        res.pixel_byte   = data;
        res.repeat_res   = rep;
        res.image_offset = 16'(count_reg);
        res.image_done   = 1'b0;
        if (step)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg >= MARK_FIRST && pos_reg < MARK_END && data != 8'h00)
                    begin
                        wrapped_next = 1'b1;
                    end
                    if (pos_reg == HEADER_LAST)
                    begin
                        pos_next = '0;
                        if (wrapped_next && WRAPPER_BYTES > 0)
                        begin
                            phase_next = PH_WRAPPER;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 10'd1;
                    end
                end
                PH_WRAPPER:
                begin
                    if (pos_reg == WRAPPER_LAST)
                    begin
                        pos_next   = '0;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        pos_next = pos_reg + 10'd1;
                    end
                end
                PH_DATA:
                begin
                    if (run_reg == 8'd0)
                    begin
                        if (data < CTRL_NOP)
                        begin
                            run_next = 8'd1;
                            lit_next = data[6:0];
                        end
                        else if (data > CTRL_NOP)
                        begin
                            run_next = 8'(RUN_BASE - {1'b0, data});
                            lit_next = '0;
                        end
                    end
                    else
                    begin
                        if (run_reg == 8'd1 && lit_reg != 7'd0)
                        begin
                            lit_next = lit_reg - 7'd1;
                        end
                        else
                        begin
                            run_next = '0;
                            lit_next = '0;
                        end
                        count_next = count_reg + COUNT_W'(rep);
                        res.valid  = 1'b1;
                        if (count_next >= IMAGE_END)
                        begin
                            res.image_done = 1'b1;
                            phase_next     = PH_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
            lit_reg     <= '0;
            run_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            wrapped_reg <= wrapped_next;
            lit_reg     <= lit_next;
            run_reg     <= run_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ----- hw/rtl/pbd_out_stage.sv -----
module pbd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  pbd_pkg::pbd_result_t res,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          pixel_byte,
    output logic [7:0]          repeat_res,
    output logic [15:0]         image_offset,
    output logic                image_done
);
    import pbd_pkg::*;

    logic        valid_reg;
    pbd_result_t data_reg;

    assign room         = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign pixel_byte   = data_reg.pixel_byte;
    assign repeat_res   = data_reg.repeat_res;
    assign image_offset = data_reg.image_offset;
    assign image_done   = data_reg.image_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res.valid;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            data_reg <= res;
        end
    end

endmodule

// ----- hw/rtl/packbits_bitmap_decoder.sv -----
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------
// input    | in_valid, in_ready  | in_byte
// result   | out_valid, out_ready| pixel_byte, repeat_res, image_offset, image_done
//
// One byte per cycle while the result register is not stalled.
// Input register, then decode and state update, then result register.
// Reset clears the decoder state; the next byte is read as file offset zero.
// A stalled result register holds the input register; in_ready then drops.
module packbits_bitmap_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_byte,
    output logic [7:0]  repeat_res,
    output logic [15:0] image_offset,
    output logic        image_done
);
    import pbd_pkg::*;

    logic        full_reg;
    logic [7:0]  byte_reg;
    logic        room;
    logic        advance;
    pbd_result_t res;

    assign advance  = full_reg && room;
    assign in_ready = !full_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    pbd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .data  (byte_reg),
        .res   (res)
    );

    pbd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .res          (res),
        .room         (room),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_byte   (pixel_byte),
        .repeat_res   (repeat_res),
        .image_offset (image_offset),
        .image_done   (image_done)
    );

endmodule

// ----- test/packbits_bitmap_decoder_test.sv -----
`timescale 1ns / 100ps

module packbits_bitmap_decoder_test;

    import pbd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AFTER  = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 30;
    localparam int TRAIL_BYTES = 20;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_WRAPPER,
        PH_DATA,
        PH_DONE
    } decode_phase_t;

    typedef struct packed {
        logic [7:0]  pixel;
        logic [7:0]  count;
        logic [15:0] offset;
        logic        done;
    } pixel_run_t;

    class decode_scoreboard;
        decode_phase_t      phase;
        logic [9:0]         file_pos;
        logic               wrapped;
        logic [6:0]         lit_left;
        logic [7:0]         run_len;
        logic [COUNT_W-1:0] decoded;
        pixel_run_t         expected_runs[$];
        int                 mismatches;

        function new();
            phase       = (HEADER_BYTES > 0) ? PH_HEADER : PH_DATA;
            file_pos    = '0;
            wrapped     = 1'b0;
            lit_left    = '0;
            run_len     = '0;
            decoded     = '0;
            mismatches  = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            pixel_run_t r;
            int         rep;
            int         left;
            case (phase)
                PH_HEADER:
                begin
                    if (file_pos >= MARK_FIRST && file_pos < MARK_END && b != 8'h00)
                        wrapped = 1'b1;
                    if (int'(file_pos) + 1 >= HEADER_BYTES)
                    begin
                        file_pos = '0;
                        phase    = (wrapped && WRAPPER_BYTES > 0) ? PH_WRAPPER : PH_DATA;
                    end
                    else
                        file_pos = file_pos + 10'd1;
                end
                PH_WRAPPER:
                begin
                    if (int'(file_pos) + 1 >= WRAPPER_BYTES)
                    begin
                        file_pos = '0;
                        phase    = PH_DATA;
                    end
                    else
                        file_pos = file_pos + 10'd1;
                end
                PH_DATA:
                begin
                    if (run_len == 8'd0)
                    begin
                        if (b < CTRL_NOP)
                        begin
                            run_len  = 8'd1;
                            lit_left = b[6:0];
                        end
                        else if (b > CTRL_NOP)
                        begin
                            run_len  = 8'(RUN_BASE - 9'(b));
                            lit_left = '0;
                        end
                    end
                    else
                    begin
                        rep = int'(run_len);
                        if (run_len == 8'd1 && lit_left > 7'd0)
                            lit_left = lit_left - 7'd1;
                        else
                        begin
                            run_len  = '0;
                            lit_left = '0;
                        end
                        left = IMAGE_BYTES - int'(decoded);
                        if (rep > left)
                            rep = left;
                        r.pixel  = b;
                        r.count  = 8'(rep);
                        r.offset = 16'(decoded);
                        decoded  = decoded + COUNT_W'(rep);
                        r.done   = (int'(decoded) >= IMAGE_BYTES);
                        if (r.done)
                            phase = PH_DONE;
                        expected_runs.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_run(logic [7:0] pixel, logic [7:0] count,
                                logic [15:0] offset, logic done);
            pixel_run_t e;
            if (expected_runs.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result pixel_byte %h repeat_res %0d image_offset %0d",
                         $time, pixel, count, offset);
                return;
            end
            e = expected_runs.pop_front();
            if (pixel !== e.pixel)
            begin
                mismatches++;
                $display("%0t: pixel_byte expected %h got %h", $time, e.pixel, pixel);
            end
            if (count !== e.count)
            begin
                mismatches++;
                $display("%0t: repeat_res expected %0d got %0d", $time, e.count, count);
            end
            if (offset !== e.offset)
            begin
                mismatches++;
                $display("%0t: image_offset expected %0d got %0d", $time, e.offset, offset);
            end
            if (done !== e.done)
            begin
                mismatches++;
                $display("%0t: image_done expected %b got %b", $time, e.done, done);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  pixel_byte;
    logic [7:0]  repeat_res;
    logic [15:0] image_offset;
    logic        image_done;

    decode_scoreboard sb = new();

    int image_fill    = 0;
    int send_calm     = 0;
    int recv_calm     = 0;
    int results_taken = 0;
    int quiet_cycles  = 0;

    packbits_bitmap_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_byte   (pixel_byte),
        .repeat_res   (repeat_res),
        .image_offset (image_offset),
        .image_done   (image_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm_left = $urandom_range(20, 80);
        return $urandom_range(0, 10);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_run(input int rep, input logic [7:0] value);
        send_byte(8'(RUN_BASE - 9'(rep)));
        send_byte(value);
        image_fill += rep;
    endtask

    task automatic send_literals(input logic [7:0] values[$]);
        send_byte(8'(values.size() - 1));
        foreach (values[i])
            send_byte(values[i]);
        image_fill += values.size();
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_runs.size() != 0) @(posedge clk);
    endtask

    task automatic send_file_head(input bit wrap);
        int         mark;
        logic [7:0] b;
        mark = $urandom_range(0, 5);
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (i >= MARK_FIRST && i < MARK_END)
                b = (wrap && i == MARK_FIRST + mark) ? 8'($urandom_range(1, 255)) : 8'h00;
            send_byte(b);
        end
        if (wrap)
            repeat (WRAPPER_BYTES) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_directed();
        logic [7:0] pkt[$];
        send_byte(CTRL_NOP);
        pkt = {8'h00};
        send_literals(pkt);
        pkt = {8'hFF, CTRL_NOP};
        send_literals(pkt);
        send_run(128, 8'hA5);
        send_run(2, 8'h5A);
        send_byte(CTRL_NOP);
        send_run(127, 8'h7F);
        pkt = {8'h01, 8'h02, 8'h04, 8'h08};
        send_literals(pkt);
        send_run(65, 8'h00);
    endtask

    task automatic send_image_body();
        int         pick;
        int         n;
        logic [7:0] pkt[$];
        while (image_fill < IMAGE_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_byte(CTRL_NOP);
            else if (pick < 5)
            begin
                n = ($urandom_range(0, 15) == 0) ? 128 : $urandom_range(1, 4);
                pkt.delete();
                repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
                send_literals(pkt);
            end
            else
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 128) : 128;
                send_run(n, 8'($urandom_range(0, 255)));
            end
        end
        repeat (TRAIL_BYTES) send_byte(8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(in_byte);
            if (out_valid && out_ready)
                sb.check_run(pixel_byte, repeat_res, image_offset, image_done);
        end
    end

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = (results_taken == HOLD_AFTER) ? HOLD_CYCLES : draw_gap(recv_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            results_taken++;
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_file_head($urandom_range(0, 1) == 1);
        send_directed();
        drain_results();
        send_image_body();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_runs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pbd_pkg.sv
hw/rtl/pbd_core.sv
hw/rtl/pbd_out_stage.sv
hw/rtl/packbits_bitmap_decoder.sv
test/packbits_bitmap_decoder_test.sv
